// ----- hdl/dnd_pkg.sv -----
// Shared types and constants for the DNS name decompressor.
// Used by the front, queue, back and top-level modules; depends on nothing.
package dnd_pkg;

   localparam logic KIND_LOAD   = 1'b0;
   localparam logic KIND_DECODE = 1'b1;

   localparam int QDEPTH = 2;

   localparam logic [7:0] CHAR_DOT = 8'h2E;
   localparam logic [1:0] PTR_TAG  = 2'b11;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_LONG  = 2'd1,
      STAT_JUMPS = 2'd2,
      STAT_RANGE = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      WALK_IDLE,
      WALK_LEN_RD,
      WALK_LEN,
      WALK_PTR,
      WALK_CH_RD,
      WALK_CH,
      WALK_FIN
   } walk_state_type;

   typedef struct packed {
      logic       kind;
      logic [8:0] offset;
      logic [7:0] byte_value;
      logic       in_range;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

// ----- hdl/dns_name_decompressor_core.sv -----
// Top level of the DNS name decompressor: front classifier, queue, walker back end.
// Depends on dnd_pkg, dnd_front, dnd_queue and dnd_back.
//
//   channel | direction | ports                                        | handshake
//   req     | in        | req_kind, req_offset, req_byte_value         | req_valid/req_ready
//   rsp     | out       | rsp_chunk, rsp_chunk_bytes, rsp_last,        | rsp_valid/rsp_ready
//           |           | rsp_consumed, rsp_status                     |
//
// In the back end, loads stream at one per cycle while the walker is idle.
// A decode walks the name out of the store twice, once if it is empty: each length byte
// is read and then examined, a pointer pair is followed, each character read and packed.
// Reset is synchronous, active high; the store holds no reset value.
// A stalled result register holds the walker; the 2-entry queue takes requests until full.
module dns_name_decompressor_core #(
   parameter int MSG_BYTES = 512,
   parameter int MAX_NAME  = 255,
   parameter int MAX_JUMPS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_kind,
   input  logic [8:0]  req_offset,
   input  logic [7:0]  req_byte_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_chunk,
   output logic [3:0]  rsp_chunk_bytes,
   output logic        rsp_last,
   output logic [8:0]  rsp_consumed,
   output logic [1:0]  rsp_status
);

   dnd_pkg::qstat_type q_stat;
   dnd_pkg::item_type  push_item, pop_item;
   logic               push, pop;

   dnd_front #(
      .MSG_BYTES (MSG_BYTES)
   ) u_front (
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_offset     (req_offset),
      .req_byte_value (req_byte_value),
      .q_stat         (q_stat),
      .push           (push),
      .push_item      (push_item)
   );

   dnd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .q_stat    (q_stat)
   );

   dnd_back #(
      .MSG_BYTES (MSG_BYTES),
      .MAX_NAME  (MAX_NAME),
      .MAX_JUMPS (MAX_JUMPS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_item          (pop_item),
      .q_stat          (q_stat),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_chunk       (rsp_chunk),
      .rsp_chunk_bytes (rsp_chunk_bytes),
      .rsp_last        (rsp_last),
      .rsp_consumed    (rsp_consumed),
      .rsp_status      (rsp_status)
   );

endmodule

// ----- hdl/dnd_front.sv -----
// Input side of the DNS name decompressor: takes request words and tags range.
// Depends on dnd_pkg; feeds dnd_queue.
module dnd_front #(
   parameter int MSG_BYTES = 512
) (
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_kind,
   input  logic [8:0]        req_offset,
   input  logic [7:0]        req_byte_value,
   input  dnd_pkg::qstat_type q_stat,
   output logic              push,
   output dnd_pkg::item_type push_item
);

   always_comb begin
      req_ready            = !q_stat.full;
      push                 = req_valid && !q_stat.full;
      push_item.kind       = req_kind;
      push_item.offset     = req_offset;
      push_item.byte_value = req_byte_value;
      push_item.in_range   = (32'(req_offset) < MSG_BYTES);
   end

endmodule

// ----- hdl/dnd_queue.sv -----
// Short FIFO between the front and the back of the DNS name decompressor.
// Depends on dnd_pkg.
module dnd_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  dnd_pkg::item_type  push_item,
   input  logic               pop,
   output dnd_pkg::item_type  pop_item,
   output dnd_pkg::qstat_type q_stat
);

   localparam int PW = (dnd_pkg::QDEPTH > 1) ? $clog2(dnd_pkg::QDEPTH) : 1;
   localparam int CW = $clog2(dnd_pkg::QDEPTH + 1);

   dnd_pkg::item_type entry_ff [dnd_pkg::QDEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              do_push, do_pop;

   always_comb begin
      q_stat.full  = (count_ff == CW'(dnd_pkg::QDEPTH));
      q_stat.empty = (count_ff == '0);
      do_push      = push && !q_stat.full;
      do_pop       = pop && !q_stat.empty;
      pop_item     = entry_ff[rd_ptr_ff];
      wr_ptr_in    = wr_ptr_ff;
      rd_ptr_in    = rd_ptr_ff;
      count_in     = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(dnd_pkg::QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(dnd_pkg::QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(dnd_pkg::QDEPTH))
      else $error("queue count overflow");

   assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree while empty");

   assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count missed a push");

endmodule

// ----- hdl/dnd_back.sv -----
// Back end of the DNS name decompressor: message store, label walker, packer.
// Depends on dnd_pkg; drains dnd_queue and drives the result register.
module dnd_back #(
   parameter int MSG_BYTES = 512,
   parameter int MAX_NAME  = 255,
   parameter int MAX_JUMPS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  dnd_pkg::item_type  q_item,
   input  dnd_pkg::qstat_type q_stat,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [63:0]        rsp_chunk,
   output logic [3:0]         rsp_chunk_bytes,
   output logic               rsp_last,
   output logic [8:0]         rsp_consumed,
   output logic [1:0]         rsp_status
);

   localparam int AW = $clog2(MSG_BYTES);
   localparam int CW = $clog2(MSG_BYTES + 512);

   logic [7:0]    store_mem [MSG_BYTES];
   logic [7:0]    rdata_ff;
   logic          rd_en, wr_en;
   logic [AW-1:0] rd_addr, wr_addr;

   dnd_pkg::walk_state_type state_ff, state_in;
   dnd_pkg::status_type     status_ff, status_in;
   logic [AW-1:0] pos_ff, pos_in;
   logic [AW-1:0] start_ff, start_in;
   logic          pass2_ff, pass2_in;
   logic          jumped_ff, jumped_in;
   logic [7:0]    wire_ff, wire_in;
   logic [6:0]    jumps_ff, jumps_in;
   logic [7:0]    tlen_ff, tlen_in;
   logic [7:0]    idx_ff, idx_in;
   logic [7:0]    cnt_ff, cnt_in;
   logic [5:0]    hi_ff, hi_in;
   logic [8:0]    consumed_ff, consumed_in;
   logic [63:0]   buf_ff, buf_in;
   logic [3:0]    fill_ff, fill_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [63:0]   rsp_chunk_ff;
   logic [3:0]    rsp_chunk_bytes_ff;
   logic          rsp_last_ff;
   logic [8:0]    rsp_consumed_ff;
   dnd_pkg::status_type rsp_status_ff;

   logic          out_free;
   logic          emit;
   logic [63:0]   emit_chunk;
   logic [3:0]    emit_bytes;
   logic          emit_last;
   logic [8:0]    emit_consumed;
   dnd_pkg::status_type emit_status;

   logic          app_en;
   logic [7:0]    app_char;
   logic [63:0]   app_buf;
   logic [3:0]    app_fill;
   logic          app_final;

   logic [7:0]    b;
   logic [CW-1:0] pos_x, start_x, lab_end;
   logic [8:0]    wire_sum, tlen_sum;
   logic [7:0]    jumps_sum;
   logic [13:0]   target;

   always_comb begin
      out_free  = !rsp_valid_ff || rsp_ready;
      b         = rdata_ff;
      pos_x     = CW'(pos_ff);
      start_x   = CW'(start_ff);
      lab_end   = pos_x + CW'(1) + CW'(b);
      target    = {hi_ff, rdata_ff};
      app_final = (9'(idx_ff) + 9'd1 == 9'(tlen_ff));

      state_in    = state_ff;
      status_in   = status_ff;
      pos_in      = pos_ff;
      start_in    = start_ff;
      pass2_in    = pass2_ff;
      jumped_in   = jumped_ff;
      wire_in     = wire_ff;
      jumps_in    = jumps_ff;
      tlen_in     = tlen_ff;
      idx_in      = idx_ff;
      cnt_in      = cnt_ff;
      hi_in       = hi_ff;
      consumed_in = consumed_ff;
      buf_in      = buf_ff;
      fill_in     = fill_ff;
      pop         = 1'b0;
      rd_en       = 1'b0;
      rd_addr     = pos_ff;
      wr_en       = 1'b0;
      wr_addr     = AW'(q_item.offset);
      app_en      = 1'b0;
      app_char    = b;
      wire_sum    = 9'(wire_ff) + 9'(b) + 9'd1;
      tlen_sum    = 9'(tlen_ff) + 9'(b) + ((tlen_ff != 8'd0) ? 9'd1 : 9'd0);
      jumps_sum   = 8'(jumps_ff) + 8'd1;
      emit          = 1'b0;
      emit_chunk    = '0;
      emit_bytes    = '0;
      emit_last     = 1'b1;
      emit_consumed = '0;
      emit_status   = dnd_pkg::STAT_OK;

      unique case (state_ff)
         dnd_pkg::WALK_IDLE: begin
            if (!q_stat.empty) begin
               pop = 1'b1;
               if (q_item.kind == dnd_pkg::KIND_LOAD) begin
                  wr_en = q_item.in_range;
               end else if (!q_item.in_range) begin
                  status_in = dnd_pkg::STAT_RANGE;
                  state_in  = dnd_pkg::WALK_FIN;
               end else begin
                  start_in  = AW'(q_item.offset);
                  pos_in    = AW'(q_item.offset);
                  pass2_in  = 1'b0;
                  jumped_in = 1'b0;
                  wire_in   = '0;
                  jumps_in  = '0;
                  tlen_in   = '0;
                  idx_in    = '0;
                  state_in  = dnd_pkg::WALK_LEN_RD;
               end
            end
         end
         dnd_pkg::WALK_LEN_RD: begin
            rd_en    = 1'b1;
            state_in = dnd_pkg::WALK_LEN;
         end
         dnd_pkg::WALK_LEN: begin
            if (b[7:6] == dnd_pkg::PTR_TAG) begin
               if (pos_x + CW'(1) >= CW'(MSG_BYTES)) begin
                  status_in = dnd_pkg::STAT_RANGE;
                  state_in  = dnd_pkg::WALK_FIN;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = AW'(pos_x + CW'(1));
                  hi_in    = b[5:0];
                  state_in = dnd_pkg::WALK_PTR;
               end
            end else if (b == 8'd0) begin
               if (32'(9'(wire_ff) + 9'd1) > MAX_NAME) begin
                  status_in = dnd_pkg::STAT_LONG;
                  state_in  = dnd_pkg::WALK_FIN;
               end else if (pass2_ff) begin
                  state_in = dnd_pkg::WALK_IDLE;
               end else begin
                  if (!jumped_ff) begin
                     consumed_in = 9'(pos_x + CW'(1) - start_x);
                  end
                  if (tlen_ff == 8'd0) begin
                     status_in = dnd_pkg::STAT_OK;
                     state_in  = dnd_pkg::WALK_FIN;
                  end else begin
                     pass2_in  = 1'b1;
                     pos_in    = start_ff;
                     jumped_in = 1'b0;
                     wire_in   = '0;
                     jumps_in  = '0;
                     idx_in    = '0;
                     state_in  = dnd_pkg::WALK_LEN_RD;
                  end
               end
            end else begin
               if (32'(wire_sum) > MAX_NAME) begin
                  status_in = dnd_pkg::STAT_LONG;
                  state_in  = dnd_pkg::WALK_FIN;
               end else if (lab_end >= CW'(MSG_BYTES)) begin
                  status_in = dnd_pkg::STAT_RANGE;
                  state_in  = dnd_pkg::WALK_FIN;
               end else if (!pass2_ff) begin
                  wire_in  = 8'(wire_sum);
                  tlen_in  = 8'(tlen_sum);
                  pos_in   = AW'(lab_end);
                  state_in = dnd_pkg::WALK_LEN_RD;
               end else if (idx_ff == 8'd0 || out_free) begin
                  app_en   = (idx_ff != 8'd0);
                  app_char = dnd_pkg::CHAR_DOT;
                  wire_in  = 8'(wire_sum);
                  pos_in   = AW'(pos_x + CW'(1));
                  cnt_in   = b;
                  state_in = dnd_pkg::WALK_CH_RD;
               end
            end
         end
         dnd_pkg::WALK_PTR: begin
            jumped_in = 1'b1;
            if (!jumped_ff && !pass2_ff) begin
               consumed_in = 9'(pos_x + CW'(2) - start_x);
            end
            if (32'(jumps_sum) > MAX_JUMPS) begin
               status_in = dnd_pkg::STAT_JUMPS;
               state_in  = dnd_pkg::WALK_FIN;
            end else if (32'(target) >= MSG_BYTES) begin
               status_in = dnd_pkg::STAT_RANGE;
               state_in  = dnd_pkg::WALK_FIN;
            end else begin
               jumps_in = 7'(jumps_sum);
               pos_in   = AW'(target);
               state_in = dnd_pkg::WALK_LEN_RD;
            end
         end
         dnd_pkg::WALK_CH_RD: begin
            rd_en    = 1'b1;
            state_in = dnd_pkg::WALK_CH;
         end
         dnd_pkg::WALK_CH: begin
            if (out_free) begin
               app_en   = 1'b1;
               app_char = b;
               pos_in   = AW'(pos_x + CW'(1));
               cnt_in   = cnt_ff - 8'd1;
               if (app_final) begin
                  state_in = dnd_pkg::WALK_IDLE;
               end else if (cnt_ff == 8'd1) begin
                  state_in = dnd_pkg::WALK_LEN_RD;
               end else begin
                  state_in = dnd_pkg::WALK_CH_RD;
               end
            end
         end
         dnd_pkg::WALK_FIN: begin
            if (out_free) begin
               emit          = 1'b1;
               emit_status   = status_ff;
               emit_consumed = (status_ff == dnd_pkg::STAT_OK) ? consumed_ff : 9'd0;
               state_in      = dnd_pkg::WALK_IDLE;
            end
         end
         default: begin
            state_in = dnd_pkg::WALK_IDLE;
         end
      endcase

      app_buf  = buf_ff | (64'(app_char) << {fill_ff[2:0], 3'b000});
      app_fill = fill_ff + 4'd1;
      if (app_en) begin
         idx_in = idx_ff + 8'd1;
         if (app_fill == 4'd8 || app_final) begin
            emit          = 1'b1;
            emit_chunk    = app_buf;
            emit_bytes    = app_fill;
            emit_last     = app_final;
            emit_consumed = consumed_ff;
            emit_status   = dnd_pkg::STAT_OK;
            buf_in        = '0;
            fill_in       = '0;
         end else begin
            buf_in  = app_buf;
            fill_in = app_fill;
         end
      end

      rsp_valid_in = emit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= q_item.byte_value;
      end
      if (rd_en) begin
         rdata_ff <= store_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dnd_pkg::WALK_IDLE;
         rsp_valid_ff <= 1'b0;
         buf_ff       <= '0;
         fill_ff      <= '0;
         pass2_ff     <= 1'b0;
         jumped_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         buf_ff       <= buf_in;
         fill_ff      <= fill_in;
         pass2_ff     <= pass2_in;
         jumped_ff    <= jumped_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff   <= status_in;
      pos_ff      <= pos_in;
      start_ff    <= start_in;
      wire_ff     <= wire_in;
      jumps_ff    <= jumps_in;
      tlen_ff     <= tlen_in;
      idx_ff      <= idx_in;
      cnt_ff      <= cnt_in;
      hi_ff       <= hi_in;
      consumed_ff <= consumed_in;
      if (emit) begin
         rsp_chunk_ff       <= emit_chunk;
         rsp_chunk_bytes_ff <= emit_bytes;
         rsp_last_ff        <= emit_last;
         rsp_consumed_ff    <= emit_consumed;
         rsp_status_ff      <= emit_status;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_chunk       = rsp_chunk_ff;
   assign rsp_chunk_bytes = rsp_chunk_bytes_ff;
   assign rsp_last        = rsp_last_ff;
   assign rsp_consumed    = rsp_consumed_ff;
   assign rsp_status      = rsp_status_ff;

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != dnd_pkg::STAT_OK) |->
         (rsp_last_ff && rsp_chunk_bytes_ff == 4'd0 && rsp_consumed_ff == 9'd0))
      else $error("error word carries name data");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_last_ff) |-> (rsp_chunk_bytes_ff == 4'd8))
      else $error("partial chunk sent before the last word");

   assert property (@(posedge clock) disable iff (reset)
      fill_ff < 4'd8)
      else $error("packing register overfilled");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff != dnd_pkg::WALK_IDLE && state_ff != dnd_pkg::WALK_FIN) |->
         (32'(pos_ff) < MSG_BYTES))
      else $error("walk position outside the store");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> (rsp_valid_ff && $stable(rsp_chunk_ff)))
      else $error("result word changed while stalled");

endmodule
